// ===== sv/sma_pkg.sv =====
// Shared types and constants for the simple moving average unit.
// No dependencies; every other module of the unit imports this package.
`default_nettype none

package sma_pkg;

    // The lookback register is 10 bits wide, so a window never exceeds 1024 samples.
    localparam int LB_W  = 10;
    localparam int CNT_W = LB_W + 1;

    localparam logic [LB_W-1:0] LB_RESET = '1;

    // Per-item flags carried from the input queue to the result.
    typedef struct packed {
        logic restart;
        logic last;
    } t_flags;

endpackage

`default_nettype wire

// ===== sv/sma_front.sv =====
// Front end: two-entry input queue that takes transactions and tags their flags.
// Depends on sma_pkg.
`default_nettype none

module sma_front #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    output logic                        o_full,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_restart,
    input  wire logic                   i_last,
    output logic                        o_q_valid,
    input  wire logic                   i_q_pop,
    output logic [SAMPLE_BITS-1:0]      o_q_sample,
    output sma_pkg::t_flags             o_q_flags
);
    import sma_pkg::*;

    localparam int QD = 2;

    logic [SAMPLE_BITS-1:0] r_sample [QD];
    t_flags                 r_flags  [QD];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;
    logic                   w_in, w_out;

    assign o_full    = (r_cnt == 2'(QD));
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_in      = i_push && !o_full;
    assign w_out     = i_q_pop && o_q_valid;

    assign o_q_sample = r_sample[r_rp];
    assign o_q_flags  = r_flags[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_sample[r_wp] <= i_sample;
            r_flags[r_wp]  <= '{restart: i_restart, last: i_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_wp <= ~r_wp;
            end
            if (w_out) begin
                r_rp <= ~r_rp;
            end
            unique case ({w_in, w_out})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/sma_window.sv =====
// Back end, window part: delay line memory, running sum, fill count, lookback register.
// Depends on sma_pkg; hands sum and count to sma_div.
`default_nettype none

module sma_window #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int SAMPLE_BITS  = 32,
    parameter int SUM_W        = SAMPLE_BITS + sma_pkg::CNT_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    input  wire logic [sma_pkg::LB_W-1:0] i_cfg_lookback,
    input  wire logic                     i_q_valid,
    output logic                          o_q_pop,
    input  wire logic [SAMPLE_BITS-1:0]   i_q_sample,
    input  wire sma_pkg::t_flags          i_q_flags,
    input  wire logic                     i_div_ready,
    output logic                          o_div_start,
    output logic [SUM_W-1:0]              o_div_sum,
    output logic [sma_pkg::CNT_W-1:0]     o_div_count,
    output logic                          o_div_last
);
    import sma_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int PW = ((AW > CNT_W) ? AW : CNT_W) + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_ADJ, ST_ISSUE} t_state;

    logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rdata;

    t_state            r_state;
    logic [LB_W-1:0]   r_lookback;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_fill;
    logic [AW-1:0]     r_slot;
    logic              r_evict;
    logic              r_last;

    logic [CNT_W-1:0]  w_lb_plus, w_len, w_base_fill;
    logic [SUM_W-1:0]  w_base_sum, w_in_ext, w_old_ext;
    logic [PW-1:0]     w_old_diff;
    logic [AW-1:0]     w_old_addr;
    logic              w_evict, w_take;

    // Window length saturates at the delay line depth.
    always_comb begin
        w_lb_plus = {1'b0, r_lookback} + CNT_W'(1);
        if (32'(w_lb_plus) > 32'(WINDOW_DEPTH)) begin
            w_len = CNT_W'(WINDOW_DEPTH);
        end else begin
            w_len = w_lb_plus;
        end
    end

    assign w_take      = (r_state == ST_IDLE) && i_q_valid;
    assign o_q_pop     = w_take;
    assign w_base_fill = i_q_flags.restart ? '0 : r_fill;
    assign w_base_sum  = i_q_flags.restart ? '0 : r_sum;
    assign w_evict     = (w_base_fill >= w_len);
    assign w_in_ext    = {{(SUM_W-SAMPLE_BITS){i_q_sample[SAMPLE_BITS-1]}}, i_q_sample};
    assign w_old_ext   = {{(SUM_W-SAMPLE_BITS){r_rdata[SAMPLE_BITS-1]}}, r_rdata};

    // Oldest slot of the window, modulo the delay line depth.
    always_comb begin
        w_old_diff = PW'(r_slot) - PW'(w_len);
        if (w_old_diff[PW-1]) begin
            w_old_diff = w_old_diff + PW'(WINDOW_DEPTH);
        end
        w_old_addr = w_old_diff[AW-1:0];
    end

    // Read-first: when the oldest slot is the one being overwritten, the old value comes out.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rdata     <= mem[w_old_addr];
            mem[r_slot] <= i_q_sample;
        end
    end

    assign o_div_start = (r_state == ST_ISSUE) && i_div_ready;
    assign o_div_sum   = r_sum;
    assign o_div_count = r_fill;
    assign o_div_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_lookback <= LB_RESET;
            r_sum      <= '0;
            r_fill     <= '0;
            r_slot     <= '0;
            r_evict    <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_sum   <= w_base_sum + w_in_ext;
                        r_fill  <= w_evict ? w_len : w_base_fill + CNT_W'(1);
                        r_evict <= w_evict;
                        r_last  <= i_q_flags.last;
                        if (32'(r_slot) == WINDOW_DEPTH - 1) begin
                            r_slot <= '0;
                        end else begin
                            r_slot <= r_slot + AW'(1);
                        end
                        r_state <= ST_ADJ;
                    end
                end
                ST_ADJ: begin
                    if (r_evict) begin
                        r_sum <= r_sum - w_old_ext;
                    end
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    if (i_div_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // A lookback write also empties the window.
            if (i_cfg_valid) begin
                r_lookback <= i_cfg_lookback;
                r_sum      <= '0;
                r_fill     <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/sma_div.sv =====
// Back end, divide part: restoring divider, one quotient bit per cycle, plus result register.
// Depends on sma_pkg; fed by sma_window.
`default_nettype none

module sma_div #(
    parameter int SAMPLE_BITS = 32,
    parameter int SUM_W       = SAMPLE_BITS + sma_pkg::CNT_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [SUM_W-1:0]         i_sum,
    input  wire logic [sma_pkg::CNT_W-1:0] i_count,
    input  wire logic                     i_last,
    output logic                          o_ready,
    output logic                          o_empty,
    input  wire logic                     i_pop,
    output logic [SAMPLE_BITS-1:0]        o_mean,
    output logic                          o_last_mean
);
    import sma_pkg::*;

    localparam int CW = $clog2(SUM_W);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_SIGN, ST_DONE} t_state;

    t_state                 r_state;
    logic [SUM_W-1:0]       r_dq;
    logic [CNT_W-1:0]       r_rem, r_den;
    logic [CW-1:0]          r_cnt;
    logic                   r_neg;
    logic                   r_last;
    logic [SAMPLE_BITS-1:0] r_mean;

    logic [CNT_W:0]   w_rem_sh;
    logic [CNT_W+1:0] w_diff;
    logic             w_qbit;

    assign w_rem_sh = {r_rem, r_dq[SUM_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_qbit   = !w_diff[CNT_W+1];

    assign o_ready     = (r_state == ST_IDLE);
    assign o_empty     = (r_state != ST_DONE);
    assign o_mean      = r_mean;
    assign o_last_mean = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_sum[SUM_W-1];
                        r_dq    <= i_sum[SUM_W-1] ? SUM_W'(0) - i_sum : i_sum;
                        r_den   <= i_count;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_last  <= i_last;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rem <= w_qbit ? w_diff[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
                    r_dq  <= {r_dq[SUM_W-2:0], w_qbit};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(SUM_W - 1)) begin
                        r_state <= ST_SIGN;
                    end
                end
                ST_SIGN: begin
                    // Quotient magnitude fits the sample width; negate back if the sum was negative.
                    r_mean  <= r_neg ? SAMPLE_BITS'(0) - r_dq[SAMPLE_BITS-1:0]
                                     : r_dq[SAMPLE_BITS-1:0];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_pop) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/simple_moving_average_unit.sv =====
// Top level of the simple moving average unit: input queue, window back end, divider.
// Depends on sma_pkg, sma_front, sma_window, sma_div.
//
//  channel   handshake                     payload
//  input     push / full                   i_sample, i_restart, i_last_sample
//  result    empty / pop                   o_mean, o_last_mean
//  config    i_cfg_valid / o_cfg_ready     i_cfg_lookback
//
// From leaving the input queue to showing on the result ports, an item passes the window's
// adjust and issue states, then the bit-serial divider, one quotient bit per cycle over the
// SAMPLE_BITS + 11 bit sum, and its sign step into the result register.
// The two-entry input queue keeps taking transactions while a result waits to be popped, until full.
// Synchronous active-low reset empties both queues and the window; lookback resets to 1023.
`default_nettype none

module simple_moving_average_unit #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int SAMPLE_BITS  = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [SAMPLE_BITS-1:0]   i_sample,
    input  wire logic                     i_restart,
    input  wire logic                     i_last_sample,
    output logic                          empty,
    input  wire logic                     pop,
    output logic [SAMPLE_BITS-1:0]        o_mean,
    output logic                          o_last_mean,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [sma_pkg::LB_W-1:0] i_cfg_lookback
);
    import sma_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    logic                   q_valid, q_pop;
    logic [SAMPLE_BITS-1:0] q_sample;
    t_flags                 q_flags;
    logic                   div_ready, div_start, div_last;
    logic [SUM_W-1:0]       div_sum;
    logic [CNT_W-1:0]       div_count;

    assign o_cfg_ready = 1'b1;

    sma_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_sample   (i_sample),
        .i_restart  (i_restart),
        .i_last     (i_last_sample),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_sample (q_sample),
        .o_q_flags  (q_flags)
    );

    sma_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_lookback (i_cfg_lookback),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_sample     (q_sample),
        .i_q_flags      (q_flags),
        .i_div_ready    (div_ready),
        .o_div_start    (div_start),
        .o_div_sum      (div_sum),
        .o_div_count    (div_count),
        .o_div_last     (div_last)
    );

    sma_div #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .SUM_W      (SUM_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_sum       (div_sum),
        .i_count     (div_count),
        .i_last      (div_last),
        .o_ready     (div_ready),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_mean      (o_mean),
        .o_last_mean (o_last_mean)
    );

endmodule

`default_nettype wire

// ===== sv/sma_checker.sv =====
// Port-level checks for simple_moving_average_unit, bound to the top level.
// Depends on simple_moving_average_unit being compiled first.
`default_nettype none

module sma_checker #(
    parameter int SAMPLE_BITS = 32
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   push,
    input wire logic                   full,
    input wire logic                   empty,
    input wire logic                   pop,
    input wire logic [SAMPLE_BITS-1:0] o_mean,
    input wire logic                   o_last_mean
);

    // Reset leaves both queues empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // Only one result is in flight, so popping it leaves nothing behind.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) |=> empty)
        else $error("second result right after a pop");

    // A waiting result holds until popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_mean) && $stable(o_last_mean)))
        else $error("waiting result changed");

    // The input queue fills only through a push transaction.
    a_full_by_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

endmodule

bind simple_moving_average_unit sma_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sma_checker (.*);

`default_nettype wire
